/* hw/rtl/tcs_pkg.sv */
// tcs_pkg: types, codes and defaults shared by the triangle contour slicer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tcs_pkg;

  localparam int DEF_MAX_LEVELS = 64;
  localparam int DEF_COORD_BITS = 32;
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 66;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_CROSS = 2'd2;

  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  localparam logic [1:0] CFG_LEVEL_START = 2'd0;
  localparam logic [1:0] CFG_LEVEL_END   = 2'd1;
  localparam logic [1:0] CFG_LEVEL_STEP  = 2'd2;

  localparam logic [1:0] OP_START_X = 2'd0;
  localparam logic [1:0] OP_START_Y = 2'd1;
  localparam logic [1:0] OP_END_X   = 2'd2;
  localparam logic [1:0] OP_END_Y   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SETUP, ST_MUL, ST_DINIT, ST_DIV, ST_WB, ST_OUT
  } tcs_state_t;

  typedef struct packed {
    logic signed [31:0] ax_in;
    logic signed [31:0] ay_in;
    logic signed [31:0] az_in;
    logic signed [31:0] bx_in;
    logic signed [31:0] by_in;
    logic signed [31:0] bz_in;
    logic signed [31:0] cx_in;
    logic signed [31:0] cy_in;
    logic signed [31:0] cz_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] height;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic setup;
    logic mul;
    logic div_init;
    logic div;
    logic wb;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic kind_cross;
    logic last;
    logic mul_done;
    logic div_done;
    logic op_last;
  } sts_t;

endpackage

/* hw/rtl/tcs_ctrl.sv */
// tcs_ctrl: sequencer for the contour slicer, one level at a time.
// Depends on tcs_pkg; drives tcs_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module tcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tcs_pkg::sts_t sts,
  output tcs_pkg::cmd_t cmd
);
  import tcs_pkg::*;

  tcs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.in_range) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.classify = 1'b1;
          state_nxt    = sts.kind_cross ? ST_SETUP : ST_OUT;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mul_done) state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = sts.op_last ? ST_OUT : ST_SETUP;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_CHECK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/tcs_datapath.sv */
// tcs_datapath: vertex store, level walker, classifier and the shared
// serial multiplier / restoring divider. Depends on tcs_pkg.
`timescale 1ns / 1ps
module tcs_datapath #(
  parameter int MAX_LEVELS = tcs_pkg::DEF_MAX_LEVELS,
  parameter int COORD_BITS = tcs_pkg::DEF_COORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  input  tcs_pkg::in_word_t in_data,
  input  tcs_pkg::cmd_t     cmd,
  output tcs_pkg::sts_t     sts,
  output tcs_pkg::out_word_t out_data
);
  import tcs_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int SH = (COORD_BITS >= 32) ? 0 : 32 - COORD_BITS;

  function automatic logic signed [31:0] wrap_c(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v <<< SH;
    return t >>> SH;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic signed [31:0] start_r, end_r;
  logic [30:0]        step_r;
  logic signed [31:0] vx_r [3];
  logic signed [31:0] vy_r [3];
  logic signed [31:0] vz_r [3];
  logic signed [31:0] z_r;
  logic signed [32:0] next_r;
  logic [LW-1:0]      lvl_r;
  logic [1:0]         e0_r, e1_r, op_r;
  out_word_t          out_r;
  logic [32:0]        ad_r, aden_r;
  logic               neg_r;
  logic signed [31:0] p_r;
  logic [65:0]        prod_r, dq_r;
  logic [32:0]        rem_r;
  logic [6:0]         cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      step_r  <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LEVEL_START: start_r <= cfg_wdata;
        CFG_LEVEL_END:   end_r   <= cfg_wdata;
        CFG_LEVEL_STEP:  step_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // classification of the current level
  logic signed [32:0] d1, d2, d3;
  logic z1, z2, z3, n1, n2, n3;
  logic le12, le23, le31, lt12, lt23, lt31;
  logic [1:0] kind_c, ce0, ce1;
  logic signed [31:0] es_x, es_y, ee_x, ee_y;
  logic signed [32:0] next_c;
  logic last_c;

  always_comb begin
    d1 = 33'(z_r) - 33'(vz_r[0]);
    d2 = 33'(z_r) - 33'(vz_r[1]);
    d3 = 33'(z_r) - 33'(vz_r[2]);
    z1 = d1 == '0; z2 = d2 == '0; z3 = d3 == '0;
    n1 = d1[32];   n2 = d2[32];   n3 = d3[32];
    le12 = z1 || z2 || (n1 != n2);
    le23 = z2 || z3 || (n2 != n3);
    le31 = z3 || z1 || (n3 != n1);
    lt12 = !z1 && !z2 && (n1 != n2);
    lt23 = !z2 && !z3 && (n2 != n3);
    lt31 = !z3 && !z1 && (n3 != n1);
    kind_c = KIND_NONE;
    ce0 = EDGE_AB;
    ce1 = EDGE_BC;
    es_x = '0; es_y = '0; ee_x = '0; ee_y = '0;
    if (z1 && z2 && z3) begin
      kind_c = KIND_NONE;
    end else if (z1 && z2) begin
      kind_c = KIND_EDGE;
      es_x = vx_r[0]; es_y = vy_r[0]; ee_x = vx_r[1]; ee_y = vy_r[1];
    end else if (z2 && z3) begin
      kind_c = KIND_EDGE;
      es_x = vx_r[1]; es_y = vy_r[1]; ee_x = vx_r[2]; ee_y = vy_r[2];
    end else if (z3 && z1) begin
      kind_c = KIND_EDGE;
      es_x = vx_r[2]; es_y = vy_r[2]; ee_x = vx_r[0]; ee_y = vy_r[0];
    end else if ((le12 && lt23) || (lt12 && le23)) begin
      kind_c = KIND_CROSS; ce0 = EDGE_AB; ce1 = EDGE_BC;
    end else if ((le23 && lt31) || (lt23 && le31)) begin
      kind_c = KIND_CROSS; ce0 = EDGE_BC; ce1 = EDGE_CA;
    end else if ((le12 && lt31) || (lt12 && le31)) begin
      kind_c = KIND_CROSS; ce0 = EDGE_AB; ce1 = EDGE_CA;
    end
    next_c = 33'(z_r) + 33'(step_r);
    last_c = (next_c > 33'(end_r)) || ((LW + 1)'(lvl_r) + 1'b1 >= (LW + 1)'(MAX_LEVELS));
  end

  // operand selection for one interpolation
  logic [1:0] e;
  logic signed [31:0] px, py, pz, qx, qy, qz, pc, qc;
  logic signed [32:0] dd, num, den;

  always_comb begin
    e = op_r[1] ? e1_r : e0_r;
    case (e)
      EDGE_AB: begin
        px = vx_r[0]; py = vy_r[0]; pz = vz_r[0];
        qx = vx_r[1]; qy = vy_r[1]; qz = vz_r[1];
      end
      EDGE_BC: begin
        px = vx_r[1]; py = vy_r[1]; pz = vz_r[1];
        qx = vx_r[2]; qy = vy_r[2]; qz = vz_r[2];
      end
      default: begin
        px = vx_r[2]; py = vy_r[2]; pz = vz_r[2];
        qx = vx_r[0]; qy = vy_r[0]; qz = vz_r[0];
      end
    endcase
    pc  = op_r[0] ? py : px;
    qc  = op_r[0] ? qy : qx;
    dd  = 33'(qc) - 33'(pc);
    num = 33'(z_r) - 33'(pz);
    den = 33'(qz) - 33'(pz);
  end

  logic [33:0] msum, dt;
  logic        dge;
  logic signed [31:0] res;

  always_comb begin
    msum = {1'b0, prod_r[65:33]} + (prod_r[0] ? {1'b0, ad_r} : 34'd0);
    dt   = {rem_r, dq_r[65]};
    dge  = dt >= {1'b0, aden_r};
    res  = neg_r ? p_r - signed'(dq_r[31:0]) : p_r + signed'(dq_r[31:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r[0] <= wrap_c(in_data.ax_in);
      vy_r[0] <= wrap_c(in_data.ay_in);
      vz_r[0] <= in_data.az_in;
      vx_r[1] <= wrap_c(in_data.bx_in);
      vy_r[1] <= wrap_c(in_data.by_in);
      vz_r[1] <= in_data.bz_in;
      vx_r[2] <= wrap_c(in_data.cx_in);
      vy_r[2] <= wrap_c(in_data.cy_in);
      vz_r[2] <= in_data.cz_in;
    end
    if (cmd.classify) begin
      e0_r   <= ce0;
      e1_r   <= ce1;
      op_r   <= OP_START_X;
      next_r <= next_c;
      out_r.kind    <= kind_c;
      out_r.height  <= z_r;
      out_r.last    <= last_c;
      out_r.start_x <= es_x; out_r.start_y <= es_y;
      out_r.end_x   <= ee_x; out_r.end_y   <= ee_y;
    end
    if (cmd.setup) begin
      ad_r   <= abs33(dd);
      aden_r <= abs33(den);
      neg_r  <= dd[32] ^ num[32] ^ den[32];
      p_r    <= pc;
      prod_r <= {33'd0, abs33(num)};
    end
    if (cmd.mul) prod_r <= {msum, prod_r[32:1]};
    if (cmd.div_init) begin
      dq_r  <= prod_r;
      rem_r <= '0;
    end
    if (cmd.div) begin
      rem_r <= dge ? 33'(dt - {1'b0, aden_r}) : dt[32:0];
      dq_r  <= {dq_r[64:0], dge};
    end
    if (cmd.wb) begin
      case (op_r)
        OP_START_X: out_r.start_x <= res;
        OP_START_Y: out_r.start_y <= res;
        OP_END_X:   out_r.end_x   <= res;
        OP_END_Y:   out_r.end_y   <= res;
        default: ;
      endcase
      op_r <= op_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r   <= '0;
      lvl_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        z_r   <= start_r;
        lvl_r <= '0;
      end else if (cmd.advance) begin
        z_r   <= next_r[31:0];
        lvl_r <= lvl_r + 1'b1;
      end
      if (cmd.setup || cmd.div_init) cnt_r <= '0;
      else if (cmd.mul || cmd.div) cnt_r <= cnt_r + 7'd1;
    end
  end

  always_comb begin
    sts.in_range   = z_r <= end_r;
    sts.kind_cross = kind_c == KIND_CROSS;
    sts.last       = out_r.last;
    sts.mul_done   = cnt_r == 7'(MUL_STEPS - 1);
    sts.div_done   = cnt_r == 7'(DIV_STEPS - 1);
    sts.op_last    = op_r == OP_END_Y;
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/triangle_contour_slicer_core.sv */
// Triangle contour slicer: takes one triangle and emits one word per contour
// level from level_start to level_end (at most MAX_LEVELS), flagging the last.
// One triangle is handled at a time. A level with no crossing is classified and
// then waits for the output; a crossing level first runs four end-point
// interpolations, each through a 33-step serial multiplier and a 66-step
// restoring divider. A range that starts above level_end yields no word.
// Depends on tcs_pkg, tcs_ctrl and tcs_datapath.
`timescale 1ns / 1ps
module triangle_contour_slicer_core #(
  parameter int MAX_LEVELS = tcs_pkg::DEF_MAX_LEVELS,
  parameter int COORD_BITS = tcs_pkg::DEF_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcs_pkg::out_word_t out_data
);
  import tcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcs_datapath #(
    .MAX_LEVELS (MAX_LEVELS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/tcs_checker.sv */
// tcs_checker: port-level assertions for the contour slicer, bound to the top.
// Depends on tcs_pkg and triangle_contour_slicer_core.
`timescale 1ns / 1ps
module tcs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tcs_pkg::out_word_t out_data
);
  import tcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // a taken triangle closes the input straight after the handshake
  a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open right after a word was taken");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_NONE || out_data.kind == KIND_EDGE ||
                   out_data.kind == KIND_CROSS))
    else $error("undefined kind code");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_NONE |->
      out_data.start_x == '0 && out_data.start_y == '0 &&
      out_data.end_x == '0 && out_data.end_y == '0)
    else $error("empty result carries coordinates");

endmodule

bind triangle_contour_slicer_core tcs_checker u_tcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/tb.sv */
// tb: self-checking testbench for triangle_contour_slicer_core, predicting each
// level word from the triangle and the level registers. Depends on tcs_pkg.
`timescale 1ns / 1ps
module tb;
  import tcs_pkg::*;

  localparam int LEVEL_LIMIT = DEF_MAX_LEVELS;
  localparam int STALL_LIMIT = 40000;
  localparam int DRAIN_WAIT = 600;
  localparam int HOLD_CYCLES = 3000;

  // keeps the expected level words of accepted triangles and checks the outputs
  class contour_board;
    out_word_t want_q[$];
    longint lv_start, lv_end, lv_step;
    longint vx[3], vy[3], vz[3];
    int errors, n_tri, n_words;

    function new();
      lv_start = 0;
      lv_end = 0;
      lv_step = 65536;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_LEVEL_START: lv_start = longint'($signed(v));
        CFG_LEVEL_END: lv_end = longint'($signed(v));
        CFG_LEVEL_STEP: lv_step = longint'(v[30:0]);
        default: ;
      endcase
    endfunction

    function int sgn(longint v);
      return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    // p + trunc(d * num / den), exact product
    function longint interp(longint p, longint d, longint num, longint den);
      longint unsigned ad, an, aden, q;
      bit neg;
      if (den == 0) return p;
      ad = d < 0 ? -d : d;
      an = num < 0 ? -num : num;
      aden = den < 0 ? -den : den;
      neg = ((d < 0) != (num < 0)) != (den < 0);
      q = (ad * an) / aden;
      return neg ? p - longint'(q) : p + longint'(q);
    endfunction

    function void crossing(int i, int j, longint z, output longint x, output longint y);
      x = interp(vx[i], vx[j] - vx[i], z - vz[i], vz[j] - vz[i]);
      y = interp(vy[i], vy[j] - vy[i], z - vz[i], vz[j] - vz[i]);
    endfunction

    function void note_input(in_word_t w);
      longint z, d1, d2, d3, x0, y0, x1, y1;
      int s12, s23, s31, cnt;
      logic [1:0] k;
      out_word_t r;
      vx[0] = w.ax_in; vy[0] = w.ay_in; vz[0] = w.az_in;
      vx[1] = w.bx_in; vy[1] = w.by_in; vz[1] = w.bz_in;
      vx[2] = w.cx_in; vy[2] = w.cy_in; vz[2] = w.cz_in;
      n_tri++;
      z = lv_start;
      cnt = 0;
      while (z <= lv_end && cnt < LEVEL_LIMIT) begin
        d1 = z - vz[0];
        d2 = z - vz[1];
        d3 = z - vz[2];
        s12 = sgn(d1) * sgn(d2);
        s23 = sgn(d2) * sgn(d3);
        s31 = sgn(d3) * sgn(d1);
        k = KIND_NONE;
        x0 = 0; y0 = 0; x1 = 0; y1 = 0;
        if (d1 == 0 && d2 == 0 && d3 == 0) begin
          k = KIND_NONE;
        end else if (d1 == 0 && d2 == 0) begin
          k = KIND_EDGE;
          x0 = vx[0]; y0 = vy[0]; x1 = vx[1]; y1 = vy[1];
        end else if (d2 == 0 && d3 == 0) begin
          k = KIND_EDGE;
          x0 = vx[1]; y0 = vy[1]; x1 = vx[2]; y1 = vy[2];
        end else if (d3 == 0 && d1 == 0) begin
          k = KIND_EDGE;
          x0 = vx[2]; y0 = vy[2]; x1 = vx[0]; y1 = vy[0];
        end else if ((s12 <= 0 && s23 < 0) || (s12 < 0 && s23 <= 0)) begin
          k = KIND_CROSS;
          crossing(0, 1, z, x0, y0);
          crossing(1, 2, z, x1, y1);
        end else if ((s23 <= 0 && s31 < 0) || (s23 < 0 && s31 <= 0)) begin
          k = KIND_CROSS;
          crossing(1, 2, z, x0, y0);
          crossing(2, 0, z, x1, y1);
        end else if ((s12 <= 0 && s31 < 0) || (s12 < 0 && s31 <= 0)) begin
          k = KIND_CROSS;
          crossing(0, 1, z, x0, y0);
          crossing(2, 0, z, x1, y1);
        end
        cnt++;
        r.kind = k;
        r.start_x = x0[31:0];
        r.start_y = y0[31:0];
        r.end_x = x1[31:0];
        r.end_y = y1[31:0];
        r.height = z[31:0];
        r.last = (z + lv_step > lv_end) || (cnt >= LEVEL_LIMIT);
        want_q = {want_q, r};
        if (r.last) break;
        z = z + lv_step;
      end
    endfunction

    function void check(out_word_t got);
      out_word_t w;
      n_words++;
      if (want_q.size() == 0) begin
        $error("level word with nothing expected: %h", got);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.kind !== w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, got.kind); errors++;
      end
      if (got.start_x !== w.start_x) begin
        $error("start_x: expected %0d, got %0d", w.start_x, got.start_x); errors++;
      end
      if (got.start_y !== w.start_y) begin
        $error("start_y: expected %0d, got %0d", w.start_y, got.start_y); errors++;
      end
      if (got.end_x !== w.end_x) begin
        $error("end_x: expected %0d, got %0d", w.end_x, got.end_x); errors++;
      end
      if (got.end_y !== w.end_y) begin
        $error("end_y: expected %0d, got %0d", w.end_y, got.end_y); errors++;
      end
      if (got.height !== w.height) begin
        $error("height: expected %0d, got %0d", w.height, got.height); errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_LEVEL_START;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  contour_board board = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cnt = 0;
  bit hold_kick = 1'b0;
  bit hold_seen = 1'b0;
  int quiet_cycles = 0;
  int n_levels_cur = 1;

  triangle_contour_slicer_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check(out_data);
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_cnt = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom % 100) >= rx_idle_pct;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic set_levels(longint s, longint e, longint st);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LEVEL_START; cfg_wdata <= s[31:0];
    @(posedge clk);
    board.set_reg(CFG_LEVEL_START, s[31:0]);
    cfg_idx <= CFG_LEVEL_END; cfg_wdata <= e[31:0];
    @(posedge clk);
    board.set_reg(CFG_LEVEL_END, e[31:0]);
    cfg_idx <= CFG_LEVEL_STEP; cfg_wdata <= {1'b0, st[30:0]};
    @(posedge clk);
    board.set_reg(CFG_LEVEL_STEP, {1'b0, st[30:0]});
    cfg_we <= 1'b0;
  endtask

  task automatic send_tri(in_word_t w);
    if (($urandom % 100) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    board.note_input(w);
  endtask

  // wait until every expected word is out and the core has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic in_word_t mk_tri(longint az, longint bz, longint cz);
    in_word_t w;
    w.ax_in = $urandom; w.ay_in = $urandom; w.az_in = az[31:0];
    w.bx_in = $urandom; w.by_in = $urandom; w.bz_in = bz[31:0];
    w.cx_in = $urandom; w.cy_in = $urandom; w.cz_in = cz[31:0];
    return w;
  endfunction

  // heights clustered around the configured levels, sometimes exactly on one
  function automatic longint rand_height();
    longint lv, h;
    lv = board.lv_start + longint'($urandom_range(0, n_levels_cur - 1)) * board.lv_step;
    case ($urandom % 4)
      0: h = lv;
      1, 2: h = lv + longint'($urandom_range(0, 4 * board.lv_step)) - 2 * board.lv_step;
      default: h = longint'($signed($urandom));
    endcase
    if (h > 64'sd2147483647 || h < -64'sd2147483648) h = longint'($signed($urandom));
    return h;
  endfunction

  initial begin
    longint s, st;
    in_word_t w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // level 0 only, reset registers
    tx_idle_pct = 12; rx_idle_pct = 64;
    set_levels(0, 0, 65536);
    send_tri(mk_tri(0, 0, 5 * 65536));
    send_tri(mk_tri(3 * 65536, 0, 0));
    send_tri(mk_tri(0, -2 * 65536, 0));
    send_tri(mk_tri(0, 0, 0));
    send_tri(mk_tri(-65536, 2 * 65536, -3 * 65536));
    send_tri(mk_tri(-65536, -2 * 65536, 3 * 65536));
    send_tri(mk_tri(2 * 65536, -65536, -65536));
    send_tri(mk_tri(0, 7 * 65536, -9 * 65536));
    send_tri(mk_tri(65536, 2 * 65536, 3 * 65536));
    w.ax_in = 32'sh8000_0000; w.ay_in = 32'sh7fff_ffff; w.az_in = 32'sh8000_0000;
    w.bx_in = 32'sh7fff_ffff; w.by_in = 32'sh8000_0000; w.bz_in = 32'sh7fff_ffff;
    w.cx_in = 32'sh8000_0000; w.cy_in = 32'sh8000_0000; w.cz_in = 32'sh7fff_ffff;
    send_tri(w);
    send_tri(mk_tri(64'sd2147483647, -64'sd2147483648, 7));
    drain();

    // empty range: no words at all
    set_levels(5 * 65536, -5 * 65536, 65536);
    send_tri(mk_tri(0, 6 * 65536, -6 * 65536));
    send_tri(mk_tri(0, 0, 0));
    drain();

    // full signed range with the largest step
    set_levels(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
    send_tri(mk_tri(-64'sd2147483648, 64'sd2147483647, 0));
    send_tri(mk_tri(longint'($signed($urandom)), longint'($signed($urandom)),
                    longint'($signed($urandom))));
    send_tri(mk_tri(-1, -1, 5));
    drain();

    // level cap reached with unit step
    set_levels(-10, 1000, 1);
    send_tri(mk_tri(-100, 5000, -7));
    send_tri(mk_tri(20, 20, 20));
    drain();

    // zero step repeats one level up to the cap
    set_levels(0, 0, 0);
    send_tri(mk_tri(65536, 2 * 65536, 65536));
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph / 5)
        0: begin tx_idle_pct = 12; rx_idle_pct = 64; end
        1: begin tx_idle_pct = 64; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      n_levels_cur = ($urandom % 8 == 0) ? $urandom_range(9, 20) : $urandom_range(1, 5);
      st = $urandom_range(1, 1 << 20);
      s = longint'($signed($urandom)) >>> 1;
      set_levels(s, s + (n_levels_cur - 1) * st + $urandom_range(0, st - 1), st);
      for (int i = 0; i < 15; i++) begin
        if (ph == 3 && i == 2) hold_kick = ~hold_kick;
        send_tri(mk_tri(rand_height(), rand_height(), rand_height()));
      end
      drain();
    end

    $display("sent %0d triangles, checked %0d level words over 19 register settings",
             board.n_tri, board.n_words);
    if (board.errors == 0 && board.want_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* triangle_contour_slicer_core.f */
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_ctrl.sv
hw/rtl/tcs_datapath.sv
hw/rtl/triangle_contour_slicer_core.sv
hw/rtl/tcs_checker.sv
test/tb.sv
